// ----- hw/rtl/rem2d_pkg.sv -----
package rem2d_pkg;

	localparam int IDX_W     = 12;   // element index
	localparam int DIM_W     = 13;   // row and column counts
	localparam int ORD_W     = 12;   // neighbour order
	localparam int SMP_W     = 32;   // sample
	localparam int CFG_IDX_W = 3;
	localparam int NB_W      = 2 * DIM_W;  // matrix positions and neighbour addresses
	localparam int DIV_CNT_W = $clog2(IDX_W);

	localparam int MAX_ELEMENTS_DEF = 4096;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_EVAL  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT,
		REG_COLUMN_COUNT,
		REG_NEIGHBOUR_ORDER,
		REG_FIND_MINIMA,
		REG_ALONG_COLUMNS
	} rem2d_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RANGE,
		S_VAL,
		S_DIV,
		S_WALK,
		S_DRAIN
	} rem2d_state_t;

endpackage

// ----- hw/rtl/relative_extrema_mask_2d.sv -----
// Relative extrema mask over a row-major sample matrix held in one single-port store.
// Input: start with mode, index and sample, taken when start is high and busy low.
// Mode write stores the sample (dropped when index lies beyond the store); busy
// stays low, so writes may follow back to back.
// Mode evaluate raises busy and gives exactly one result: done is high for one
// cycle with extremum, element_index and out_of_range. The receiver cannot
// hold a result off; it is taken in the cycle that done is high.
// In evaluate, a range check answers at once for an index out of range or order 0;
// else the element is read, then within a row the column is found, then the walk
// reads the neighbours, one side and then the other for each step outwards, at
// most neighbour_order steps; it stops once both sides pass the matrix edge, and
// a failing neighbour caught inside the walk ends it without the final drain state.
// Each step reads one neighbour through the store's single port; the row case finds
// the column of the element with a 12-step bit-serial remainder.
// Configuration: cfg_valid / cfg_ready (always ready) with cfg_index and cfg_data; the
// user writes these only while the block is idle, which the block does not enforce.
// Reset sets the registers to 1 row, 1 column, order 1, maxima, within a row; the
// store content is undefined until written and is not cleared.
module relative_extrema_mask_2d
	import rem2d_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    start,
	output logic                    busy,
	input  logic                    mode,
	input  logic [IDX_W-1:0]        index,
	input  logic signed [SMP_W-1:0] sample,

	output logic                    done,
	output logic                    extremum,
	output logic [IDX_W-1:0]        element_index,
	output logic                    out_of_range,

	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [DIM_W-1:0]        cfg_data
);

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam logic [NB_W-1:0] MAX_W = NB_W'(MAX_ELEMENTS);

	rem2d_state_t state_q, state_d;

	logic [DIM_W-1:0] row_q;
	logic [DIM_W-1:0] col_q;
	logic [ORD_W-1:0] order_q;
	logic             min_q;
	logic             along_q;

	logic [IDX_W-1:0]        idx_q;
	logic [NB_W-1:0]         total_q;
	logic signed [SMP_W-1:0] val_q;
	logic [DIM_W-1:0]        c_q;
	logic [ORD_W-1:0]        j_q;
	logic                    side_q;
	logic [NB_W-1:0]         off_q;
	logic                    pend_s1;

	logic                    done_q;
	logic                    extremum_q;
	logic                    out_of_range_q;
	logic [IDX_W-1:0]        element_index_q;

	logic                    mem_we;
	logic                    mem_re;
	logic [NB_W-1:0]         mem_addr;
	logic signed [SMP_W-1:0] rd_data;

	logic                    div_start;
	logic                    div_done;
	logic [DIM_W-1:0]        div_rem;

	logic                    emit;
	logic                    emit_ext;
	logic                    emit_oor;
	logic                    issue;

	logic [NB_W-1:0]  idx_w;
	logic [NB_W-1:0]  index_w;
	logic             idx_in_store;
	logic             index_in_store;
	logic [DIM_W-1:0] step;
	logic             left_ok;
	logic             right_ok;
	logic [NB_W-1:0]  nb_addr;
	logic             nb_ok;
	logic             nb_in_store;
	logic             walk_last;
	logic             fail;

	assign idx_w          = NB_W'(idx_q);
	assign index_w        = NB_W'(index);
	assign idx_in_store   = idx_w < MAX_W;
	assign index_in_store = index_w < MAX_W;
	assign step           = along_q ? DIM_W'(1) : col_q;

	// neighbours beyond the matrix edge are skipped, both sides move outwards
	assign left_ok  = along_q ? ({1'b0, j_q} <= c_q) : (off_q <= idx_w);
	assign right_ok = along_q ? (({1'b0, c_q} + {2'b00, j_q}) < {1'b0, col_q})
	                          : ((idx_w + off_q) < total_q);
	assign nb_addr     = side_q ? (idx_w + off_q) : (idx_w - off_q);
	assign nb_ok       = side_q ? right_ok : left_ok;
	assign nb_in_store = nb_addr < MAX_W;
	assign walk_last   = (side_q && (j_q == order_q)) || (!left_ok && !right_ok);

	// compare against the neighbour read in the previous cycle, ties pass
	assign fail = pend_s1 && (min_q ? (val_q > rd_data) : (val_q < rd_data));

	always_comb begin
		if (state_q == S_IDLE) begin
			mem_addr = index_w;
		end else if (state_q == S_RANGE) begin
			mem_addr = idx_w;
		end else begin
			mem_addr = nb_addr;
		end
	end

	rem2d_store #(
		.DEPTH (MAX_ELEMENTS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr[AW-1:0]),
		.wdata (sample),
		.rdata (rd_data)
	);

	rem2d_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (idx_q),
		.divisor   (col_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		div_start = 1'b0;
		emit      = 1'b0;
		emit_ext  = 1'b0;
		emit_oor  = 1'b0;
		issue     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (mode == MODE_EVAL) begin
						state_d = S_RANGE;
					end else if (mode == MODE_WRITE) begin
						mem_we = index_in_store;
					end
				end
			end
			S_RANGE: begin
				if (idx_w >= total_q) begin
					emit     = 1'b1;
					emit_oor = 1'b1;
					state_d  = S_IDLE;
				end else if (order_q == '0) begin
					emit     = 1'b1;
					emit_ext = 1'b1;
					state_d  = S_IDLE;
				end else begin
					mem_re  = idx_in_store;
					state_d = S_VAL;
				end
			end
			S_VAL: begin
				if (along_q) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end else begin
					state_d = S_WALK;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				issue  = nb_ok && nb_in_store;
				mem_re = issue;
				if (fail) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end else if (walk_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				emit     = 1'b1;
				emit_ext = !fail;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= DIM_W'(1);
			col_q   <= DIM_W'(1);
			order_q <= ORD_W'(1);
			min_q   <= 1'b0;
			along_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_COUNT:       row_q   <= cfg_data;
				REG_COLUMN_COUNT:    col_q   <= cfg_data;
				REG_NEIGHBOUR_ORDER: order_q <= cfg_data[ORD_W-1:0];
				REG_FIND_MINIMA:     min_q   <= cfg_data[0];
				REG_ALONG_COLUMNS:   along_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pend_s1 <= issue;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			idx_q   <= index;
			total_q <= NB_W'(row_q) * NB_W'(col_q);
		end
		if (state_q == S_VAL) begin
			// an element beyond the store reads as zero
			val_q  <= idx_in_store ? rd_data : '0;
			j_q    <= ORD_W'(1);
			side_q <= 1'b0;
			off_q  <= NB_W'(step);
		end
		if (state_q == S_DIV && div_done) begin
			c_q <= div_rem;
		end
		if (state_q == S_WALK) begin
			side_q <= !side_q;
			if (side_q) begin
				j_q   <= j_q + 1'b1;
				off_q <= off_q + NB_W'(step);
			end
		end
		if (emit) begin
			extremum_q      <= emit_ext;
			out_of_range_q  <= emit_oor;
			element_index_q <= idx_q;
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign extremum      = extremum_q;
	assign out_of_range  = out_of_range_q;
	assign element_index = element_index_q;

	a_oor_not_extremum: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(out_of_range_q && extremum_q))
		else $error("out-of-range result marked as extremum");

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store read and write in the same cycle");

	a_pend_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(state_q == S_WALK))
		else $error("neighbour read pending outside the walk");

	a_done_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != S_IDLE))
		else $error("result strobe without an evaluation");

endmodule

// ----- hw/rtl/rem2d_store.sv -----
module rem2d_store
	import rem2d_pkg::*;
#(
	parameter int DEPTH = MAX_ELEMENTS_DEF,
	parameter int AW    = $clog2(MAX_ELEMENTS_DEF)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic                    re,
	input  logic [AW-1:0]           addr,
	input  logic signed [SMP_W-1:0] wdata,
	output logic signed [SMP_W-1:0] rdata
);

	logic signed [SMP_W-1:0] mem [DEPTH];
	logic signed [SMP_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/rem2d_div.sv -----
module rem2d_div
	import rem2d_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IDX_W-1:0] dividend,
	input  logic [DIM_W-1:0] divisor,
	output logic             done,
	output logic [DIM_W-1:0] remainder
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0]     num_q;
	logic [DIM_W-1:0]     rem_q;
	logic [DIM_W:0]       trial;
	logic                 fits;
	logic [DIM_W-1:0]     rem_d;

	// restoring division, one quotient bit a cycle, only the remainder is kept
	assign trial = {rem_q, num_q[IDX_W-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign rem_d = fits ? DIM_W'(trial - {1'b0, divisor}) : DIM_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(IDX_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[IDX_W-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
